[rtl/pslb_pkg.sv]
// Shared types and codes for the per-level segment list buffer.
package pslb_pkg;

	localparam int MODE_W    = 2;
	localparam int LEVEL_W   = 3;
	localparam int SEG_W     = 16;
	localparam int ST_W      = 2;
	localparam int CNT_OUT_W = 6;

	localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic load;
		logic append;
		logic set_ok;
		logic set_missing;
		logic set_full;
		logic scan_start;
		logic scan;
		logic shift_start;
		logic shift;
		logic drop;
		logic tail_rd;
		logic finish;
	} pslb_cmd_t;

	typedef struct packed {
		logic lvl_ok;
		logic is_add;
		logic is_consume;
		logic full;
		logic empty;
		logic hit;
		logic scan_last;
		logic more;
	} pslb_stat_t;

endpackage

[rtl/pslb_dp.sv]
// Datapath: request registers, list memory, per-level counts, scan and shift indexes, result.
module pslb_dp import pslb_pkg::*; #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MODE_W-1:0]    mode,
	input  logic [LEVEL_W-1:0]   level,
	input  logic [SEG_W-1:0]     segment,
	input  pslb_cmd_t            cmd,
	output pslb_stat_t           stat,
	output logic                 done,
	output logic [ST_W-1:0]      status,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [SEG_W-1:0]     last_segment,
	output logic                 last_valid
);

	localparam int NENT = LEVELS * DEPTH;
	localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [SEG_W-1:0]     mem [NENT];
	logic [SEG_W-1:0]     rdata_q;
	logic [MODE_W-1:0]    mode_q;
	logic [LEVEL_W-1:0]   lvl_q;
	logic [SEG_W-1:0]     seg_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        cidx_s1;
	logic                 vld_s1;
	logic                 wvld_s1;
	logic [CW-1:0]        widx_s1;
	logic [ST_W-1:0]      st_q;
	logic [CW-1:0]        level_count_q [LEVELS];
	logic                 done_q;
	logic [ST_W-1:0]      status_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	logic [SEG_W-1:0]     last_segment_q;
	logic                 last_valid_q;

	logic          in_ok;
	logic          lvl_ok;
	logic [LW-1:0] lvl_idx;
	logic [AW-1:0] base;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] idx_p1;
	logic          more;
	logic [AW-1:0] raddr;

	assign in_ok   = int'(level) < LEVELS;
	assign lvl_ok  = int'(lvl_q) < LEVELS;
	assign lvl_idx = LW'(lvl_q);
	assign base    = lvl_ok ? AW'(int'(lvl_idx) * DEPTH) : '0;
	assign cnt_m1  = cnt_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign more    = idx_p1 < cnt_q;

	always_comb begin
		if (cmd.shift) begin
			raddr = more ? base + AW'(idx_p1) : base;
		end else if (cmd.tail_rd) begin
			raddr = (cnt_q != '0) ? base + AW'(cnt_m1) : base;
		end else begin
			raddr = base + AW'(idx_q);
		end
	end

	assign stat.lvl_ok     = lvl_ok;
	assign stat.is_add     = mode_q == MODE_ADD;
	assign stat.is_consume = mode_q == MODE_CONSUME;
	assign stat.full       = cnt_q == CW'(DEPTH);
	assign stat.empty      = cnt_q == '0;
	assign stat.hit        = vld_s1 && (rdata_q == seg_q);
	assign stat.scan_last  = vld_s1 && (cidx_s1 == cnt_m1);
	assign stat.more       = more;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[base + AW'(cnt_q)] <= seg_q;
		end else if (wvld_s1) begin
			mem[base + AW'(widx_s1)] <= rdata_q;
		end
		rdata_q <= mem[raddr];
		cidx_s1 <= idx_q;
		widx_s1 <= idx_q;
		if (cmd.load) begin
			mode_q <= mode;
			lvl_q  <= level;
			seg_q  <= segment;
		end
		if (cmd.set_ok) begin
			st_q <= ST_OK;
		end else if (cmd.set_missing) begin
			st_q <= ST_MISSING;
		end else if (cmd.set_full) begin
			st_q <= ST_FULL;
		end
		if (cmd.finish) begin
			status_q       <= st_q;
			entry_count_q  <= CNT_OUT_W'(cnt_q);
			last_segment_q <= (cnt_q == '0) ? '0 : rdata_q;
			last_valid_q   <= cnt_q != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			wvld_s1 <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				level_count_q[i] <= '0;
			end
		end else begin
			vld_s1  <= cmd.scan;
			wvld_s1 <= cmd.shift && more;
			done_q  <= cmd.finish;
			if (cmd.load) begin
				cnt_q <= in_ok ? level_count_q[LW'(level)] : '0;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.drop) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.shift_start) begin
				idx_q <= cidx_s1;
			end else if (cmd.scan_start) begin
				idx_q <= '0;
			end else if ((cmd.scan || cmd.shift) && more) begin
				idx_q <= idx_p1;
			end
			if (cmd.finish && lvl_ok) begin
				level_count_q[lvl_idx] <= cnt_q;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign last_segment = last_segment_q;
	assign last_valid   = last_valid_q;

endmodule

[rtl/pslb_ctrl.sv]
// Controller: sequences the check, scan, shift, drop and tail read of one request.
module pslb_ctrl import pslb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pslb_stat_t stat,
	output pslb_cmd_t  cmd,
	output logic       busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DROP  = 3'd4;
	localparam logic [2:0] S_TAIL  = 3'd5;
	localparam logic [2:0] S_TAILW = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_TAIL;
				if (!stat.lvl_ok) begin
					cmd.set_full    = stat.is_add;
					cmd.set_missing = !stat.is_add;
				end else if (stat.is_add) begin
					cmd.set_full = stat.full;
					cmd.append   = !stat.full;
					cmd.set_ok   = !stat.full;
				end else if (stat.empty) begin
					cmd.set_missing = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					cmd.set_ok = 1'b1;
					if (stat.is_consume) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else begin
						state_d = S_TAIL;
					end
				end else if (stat.scan_last) begin
					cmd.set_missing = 1'b1;
					state_d         = S_TAIL;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (!stat.more) begin
					state_d = S_DROP;
				end
			end
			S_DROP: begin
				cmd.drop = 1'b1;
				state_d  = S_TAIL;
			end
			S_TAIL: begin
				cmd.tail_rd = 1'b1;
				state_d     = S_TAILW;
			end
			S_TAILW: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

[rtl/per_level_segment_list_buffer_unit.sv]
// Top level of the per-level segment list buffer.
// One request is taken when start is high while busy is low; busy then stays high until the
// result is produced, and done strobes for one cycle with status, entry_count, last_segment
// and last_valid. The receiver cannot stall: the result must be captured in that cycle.
// Every list lives in one single-port-read memory that is searched one entry per cycle, so
// the shortest requests are an add or one to an empty or absent level, and the longest are
// a search over the whole list or a removal that shifts the tail of the list down one entry
// per cycle. A new request may be started in the cycle that done is shown.
module per_level_segment_list_buffer_unit import pslb_pkg::*; #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [LEVEL_W-1:0]   level,
	input  logic [SEG_W-1:0]     segment,
	output logic                 done,
	output logic [ST_W-1:0]      status,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [SEG_W-1:0]     last_segment,
	output logic                 last_valid
);

	pslb_cmd_t  cmd;
	pslb_stat_t stat;

	pslb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pslb_dp #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode),
		.level          (level),
		.segment        (segment),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.entry_count    (entry_count),
		.last_segment   (last_segment),
		.last_valid     (last_valid)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still running");

	a_empty_tail: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_valid |-> last_segment == '0)
		else $error("empty level reports a nonzero last segment");

endmodule
